// File: rtl/core/bilinear_pixel_resampler_defines.svh
// Assertion macros for the bilinear pixel resampler.
`ifndef BILINEAR_PIXEL_RESAMPLER_DEFINES_SVH
`define BILINEAR_PIXEL_RESAMPLER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BRP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define BRP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/brp_pkg.sv
// Shared types and constants of the bilinear pixel resampler.
package brp_pkg;

    localparam int COORD_W    = 12;
    localparam int CHAN_W     = 8;
    localparam int NUM_CHAN   = 3;
    localparam int PIXEL_W    = CHAN_W * NUM_CHAN;
    localparam int SIZE_REG_W = 9;
    localparam int SIZE_W     = 13;
    localparam int STEP_W     = 24;
    localparam int FRAC_W     = 17;
    localparam int PROD_W     = COORD_W + 1 + STEP_W;
    localparam int POS_INT_W  = PROD_W - FRAC_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [PROD_W-1:0] HALF_POS = PROD_W'(65536);
    localparam logic [FRAC_W:0]   FRAC_ONE = (FRAC_W + 1)'(131072);

    localparam logic OP_WRITE   = 1'b0;
    localparam logic OP_REQUEST = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_HORIZONTAL = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_VERTICAL   = 2'd3;

    localparam logic [SIZE_REG_W-1:0] SIZE_RESET = 9'd256;
    localparam logic [STEP_W-1:0]     STEP_RESET = 24'd131072;

    typedef struct packed {
        logic valid;
        logic first;
    } brp_acc_ctrl_t;

endpackage

// File: rtl/core/brp_store.sv
// Frame store: single-port synchronous memory with registered read data.
module brp_store #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                              clk,
    input  logic                              we,
    input  logic [$clog2(MAX_WIDTH)-1:0]      col,
    input  logic [$clog2(MAX_HEIGHT)-1:0]     row,
    input  logic [brp_pkg::PIXEL_W-1:0]       wdata,
    output logic [brp_pkg::PIXEL_W-1:0]       rdata
);
    import brp_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);

    logic [PIXEL_W-1:0] mem [DEPTH];
    logic [PIXEL_W-1:0] rdata_reg;
    logic [AW-1:0]      addr;

    assign addr  = AW'(row) * AW'(MAX_WIDTH) + AW'(col);
    assign rdata = rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        else
        begin
            rdata_reg <= mem[addr];
        end
    end

endmodule

// File: rtl/core/brp_locate.sv
// Axis mapper: source position, clamped neighbour index and axis weights.
module brp_locate #(
    parameter int MAX_SIZE    = 256,
    parameter int WEIGHT_BITS = 11
) (
    input  logic                            clk,
    input  logic                            load,
    input  logic [brp_pkg::COORD_W-1:0]     coord,
    input  logic [brp_pkg::STEP_W-1:0]      step,
    input  logic [brp_pkg::SIZE_W-1:0]      size,
    output logic [$clog2(MAX_SIZE)-1:0]     idx,
    output logic [WEIGHT_BITS:0]            w0,
    output logic [WEIGHT_BITS:0]            w1
);
    import brp_pkg::*;

    localparam int IW = $clog2(MAX_SIZE);
    localparam int TW = FRAC_W + 1 + WEIGHT_BITS;

    logic [PROD_W-1:0]    prod_reg;
    logic [PROD_W-1:0]    up;
    logic [POS_INT_W-1:0] ipos;
    logic [FRAC_W-1:0]    frac;
    logic [IW-1:0]        idx_next;
    logic [FRAC_W:0]      comp;
    logic [TW-1:0]        tw;
    logic [WEIGHT_BITS:0] w0_next;
    logic [IW-1:0]        idx_reg;
    logic [WEIGHT_BITS:0] w0_reg;
    logic [WEIGHT_BITS:0] w1_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_reg <= PROD_W'({coord, 1'b1}) * PROD_W'(step);
        end
    end

    always_comb
    begin
        up   = prod_reg - HALF_POS;
        ipos = up[PROD_W-1:FRAC_W];
        if (prod_reg < HALF_POS)
        begin
            idx_next = '0;
            frac     = '0;
        end
        else if (ipos >= POS_INT_W'(size) - POS_INT_W'(1))
        begin
            idx_next = IW'(size - SIZE_W'(2));
            frac     = '0;
        end
        else
        begin
            idx_next = ipos[IW-1:0];
            frac     = up[FRAC_W-1:0];
        end
        comp    = FRAC_ONE - {1'b0, frac};
        tw      = {comp, {WEIGHT_BITS{1'b0}}} + TW'(HALF_POS);
        w0_next = tw[TW-1:FRAC_W];
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        w0_reg  <= w0_next;
        w1_reg  <= (WEIGHT_BITS + 1)'(1 << WEIGHT_BITS) - w0_next;
    end

    assign idx = idx_reg;
    assign w0  = w0_reg;
    assign w1  = w1_reg;

endmodule

// File: rtl/core/brp_blend.sv
// Blend accumulator: weighted sum of neighbour pixels per channel.
module brp_blend #(
    parameter int WEIGHT_BITS = 11
) (
    input  logic                            clk,
    input  brp_pkg::brp_acc_ctrl_t          ctrl,
    input  logic [2*WEIGHT_BITS+1:0]        weight,
    input  logic [brp_pkg::PIXEL_W-1:0]     pixel,
    output logic [brp_pkg::PIXEL_W-1:0]     result
);
    import brp_pkg::*;

    localparam int CWW   = 2 * WEIGHT_BITS + 2;
    localparam int ACC_W = CHAN_W + 2 * WEIGHT_BITS;
    localparam int MUL_W = CHAN_W + CWW;

    logic [ACC_W-1:0] acc_reg  [NUM_CHAN];
    logic [ACC_W-1:0] acc_next [NUM_CHAN];
    logic [MUL_W-1:0] prod     [NUM_CHAN];

    always_comb
    begin
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            prod[c]     = MUL_W'(pixel[c*CHAN_W +: CHAN_W]) * MUL_W'(weight);
            acc_next[c] = (ctrl.first ? ACC_W'(0) : acc_reg[c]) + prod[c][ACC_W-1:0];
            result[c*CHAN_W +: CHAN_W] = acc_reg[c][ACC_W-1 -: CHAN_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.valid)
        begin
            for (int c = 0; c < NUM_CHAN; c++)
            begin
                acc_reg[c] <= acc_next[c];
            end
        end
    end

endmodule

// File: rtl/core/bilinear_pixel_resampler.sv
// Top level: request sequencer, configuration registers and result output.
// Writes may follow back to back.
// A request passes through one multiply stage, one locate stage, four reads of the single store port
// and one drain; busy is high from the locate stage through the drain, and the strobe follows the drain.
// The receiver cannot stall; each result stands for one cycle with strobe high.
// Reset clears control and configuration registers; the frame store is not cleared.
module bilinear_pixel_resampler #(
    parameter int MAX_WIDTH   = 256,
    parameter int MAX_HEIGHT  = 256,
    parameter int WEIGHT_BITS = 11
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               operation,
    input  logic [brp_pkg::COORD_W-1:0]        column,
    input  logic [brp_pkg::COORD_W-1:0]        row,
    input  logic [brp_pkg::CHAN_W-1:0]         in_chan0,
    input  logic [brp_pkg::CHAN_W-1:0]         in_chan1,
    input  logic [brp_pkg::CHAN_W-1:0]         in_chan2,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [brp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [brp_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                               strobe,
    output logic [brp_pkg::CHAN_W-1:0]         out_chan0,
    output logic [brp_pkg::CHAN_W-1:0]         out_chan1,
    output logic [brp_pkg::CHAN_W-1:0]         out_chan2
);
    import brp_pkg::*;

    `include "bilinear_pixel_resampler_defines.svh"

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int CWW = 2 * WEIGHT_BITS + 2;

    localparam logic [SIZE_W-1:0] MAX_W_SZ = SIZE_W'(MAX_WIDTH);
    localparam logic [SIZE_W-1:0] MAX_H_SZ = SIZE_W'(MAX_HEIGHT);
    localparam logic [SIZE_W-1:0] MIN_SZ   = SIZE_W'(2);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOC  = 2'd1;
    localparam logic [1:0] S_READ = 2'd2;
    localparam logic [1:0] S_WAIT = 2'd3;

    logic [1:0]            state_reg, state_next;
    logic [1:0]            nb_reg, nb_next;
    logic                  done_reg;
    brp_acc_ctrl_t         acc_ctrl_reg, acc_ctrl_next;
    logic [CWW-1:0]        wk_reg;

    logic [SIZE_REG_W-1:0] source_width_reg;
    logic [SIZE_REG_W-1:0] source_height_reg;
    logic [STEP_W-1:0]     step_horizontal_reg;
    logic [STEP_W-1:0]     step_vertical_reg;

    logic [SIZE_W-1:0]     size_x, size_y;
    logic                  accept, req_accept, mem_we;
    logic [CW-1:0]         sx, mem_col;
    logic [RW-1:0]         sy, mem_row;
    logic [WEIGHT_BITS:0]  wx0, wx1, wy0, wy1, wx_sel, wy_sel;
    logic [PIXEL_W-1:0]    rdata, blend_out;

    assign busy       = (state_reg != S_IDLE);
    assign accept     = start && !busy;
    assign req_accept = accept && (operation == OP_REQUEST);
    assign mem_we     = accept && (operation == OP_WRITE)
                        && ((COORD_W + 1)'(column) < (COORD_W + 1)'(MAX_WIDTH))
                        && ((COORD_W + 1)'(row) < (COORD_W + 1)'(MAX_HEIGHT));
    assign cfg_ready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_width_reg    <= SIZE_RESET;
            source_height_reg   <= SIZE_RESET;
            step_horizontal_reg <= STEP_RESET;
            step_vertical_reg   <= STEP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SOURCE_WIDTH:    source_width_reg    <= cfg_data[SIZE_REG_W-1:0];
                REG_SOURCE_HEIGHT:   source_height_reg   <= cfg_data[SIZE_REG_W-1:0];
                REG_STEP_HORIZONTAL: step_horizontal_reg <= cfg_data[STEP_W-1:0];
                REG_STEP_VERTICAL:   step_vertical_reg   <= cfg_data[STEP_W-1:0];
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        size_x = SIZE_W'(source_width_reg);
        if (size_x < MIN_SZ)
        begin
            size_x = MIN_SZ;
        end
        else if (size_x > MAX_W_SZ)
        begin
            size_x = MAX_W_SZ;
        end
        size_y = SIZE_W'(source_height_reg);
        if (size_y < MIN_SZ)
        begin
            size_y = MIN_SZ;
        end
        else if (size_y > MAX_H_SZ)
        begin
            size_y = MAX_H_SZ;
        end
    end

    brp_locate #(
        .MAX_SIZE    (MAX_WIDTH),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_locate_x (
        .clk   (clk),
        .load  (req_accept),
        .coord (column),
        .step  (step_horizontal_reg),
        .size  (size_x),
        .idx   (sx),
        .w0    (wx0),
        .w1    (wx1)
    );

    brp_locate #(
        .MAX_SIZE    (MAX_HEIGHT),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_locate_y (
        .clk   (clk),
        .load  (req_accept),
        .coord (row),
        .step  (step_vertical_reg),
        .size  (size_y),
        .idx   (sy),
        .w0    (wy0),
        .w1    (wy1)
    );

    // neighbour order: bit 1 steps the column, bit 0 steps the row
    always_comb
    begin
        wx_sel  = nb_reg[1] ? wx1 : wx0;
        wy_sel  = nb_reg[0] ? wy1 : wy0;
        mem_col = busy ? (sx + CW'(nb_reg[1])) : column[CW-1:0];
        mem_row = busy ? (sy + RW'(nb_reg[0])) : row[RW-1:0];
    end

    brp_store #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .col   (mem_col),
        .row   (mem_row),
        .wdata ({in_chan2, in_chan1, in_chan0}),
        .rdata (rdata)
    );

    always_ff @(posedge clk)
    begin
        wk_reg <= CWW'(wx_sel) * CWW'(wy_sel);
    end

    always_comb
    begin
        state_next          = state_reg;
        nb_next             = nb_reg;
        acc_ctrl_next.valid = 1'b0;
        acc_ctrl_next.first = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_accept)
                begin
                    state_next = S_LOC;
                end
            end
            S_LOC:
            begin
                nb_next    = '0;
                state_next = S_READ;
            end
            S_READ:
            begin
                acc_ctrl_next.valid = 1'b1;
                acc_ctrl_next.first = (nb_reg == 2'd0);
                nb_next             = nb_reg + 2'd1;
                if (nb_reg == 2'd3)
                begin
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            nb_reg       <= '0;
            acc_ctrl_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            nb_reg       <= nb_next;
            acc_ctrl_reg <= acc_ctrl_next;
            done_reg     <= (state_reg == S_WAIT);
        end
    end

    brp_blend #(
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_blend (
        .clk    (clk),
        .ctrl   (acc_ctrl_reg),
        .weight (wk_reg),
        .pixel  (rdata),
        .result (blend_out)
    );

    assign strobe    = done_reg;
    assign out_chan0 = blend_out[0*CHAN_W +: CHAN_W];
    assign out_chan1 = blend_out[1*CHAN_W +: CHAN_W];
    assign out_chan2 = blend_out[2*CHAN_W +: CHAN_W];

    `BRP_ASSERT_NEXT(a_request_busy, req_accept, busy, "request accepted but busy not raised")
    `BRP_ASSERT_SAME(a_strobe_idle, strobe, !busy, "result strobe while sequencer busy")
    `BRP_ASSERT_NEXT(a_strobe_single, strobe, !strobe, "result strobe longer than one cycle")
    `BRP_ASSERT_NEXT(a_drain_result, (state_reg == S_WAIT), strobe, "drain not followed by result")
    `BRP_ASSERT_SAME(a_no_write_busy, busy, !mem_we, "store write while reading neighbours")

endmodule
